// File: rtl/vtp_pkg.sv
package vtp_pkg;

    localparam int WORD_W    = 32;
    localparam int MAT_REGS  = 8;
    localparam int REG_W     = 64;
    localparam int IDX_W     = 3;
    // quotient bits developed one per stage; larger quotients saturate anyway
    localparam int DIV_STEPS = 33;

    // register indexes of the matrix rows
    localparam logic [IDX_W-1:0] REG_ROW0_C01 = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_C23 = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_C01 = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_C23 = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW2_C01 = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW2_C23 = 3'd5;
    localparam logic [IDX_W-1:0] REG_ROW3_C01 = 3'd6;
    localparam logic [IDX_W-1:0] REG_ROW3_C23 = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [MAT_REGS-1:0][REG_W-1:0] t_mat;
    typedef logic [IDX_W-1:0] t_cfg_idx;

    function automatic t_word mat_entry(input t_mat m, input int row, input int col);
        logic [REG_W-1:0] r;
        r = m[IDX_W'((row << 1) | ((col >> 1) & 1))];
        return ((col & 1) != 0) ? t_word'(r[63:32]) : t_word'(r[31:0]);
    endfunction

endpackage

// File: rtl/vtp_in_if.sv
interface vtp_in_if;
    import vtp_pkg::*;
    logic  valid;
    logic  ready;
    t_word in_x;
    t_word in_y;
    t_word in_z;
    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

// File: rtl/vtp_out_if.sv
interface vtp_out_if;
    import vtp_pkg::*;
    logic  valid;
    logic  ready;
    t_word out_x;
    t_word out_y;
    t_word out_z;
    logic  w_was_zero;
    logic  saturated;
    modport source (output valid, output out_x, output out_y, output out_z,
                    output w_was_zero, output saturated, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input w_was_zero, input saturated, output ready);
endinterface

// File: rtl/vtp_mul.sv
module vtp_mul #(
    parameter int FRAC_BITS = 16,
    parameter int SW        = 50
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  vtp_pkg::t_word        i_x,
    input  vtp_pkg::t_word        i_y,
    input  vtp_pkg::t_word        i_z,
    input  vtp_pkg::t_mat         i_mat,
    output logic signed [SW-1:0]  o_v [4]
);
    import vtp_pkg::*;

    t_word                 pt [3];
    logic signed [63:0]    r_prod [3][4];
    logic signed [SW-1:0]  r_pa [4];
    logic signed [SW-1:0]  r_pb [4];
    logic signed [SW-1:0]  r_v [4];

    assign pt[0] = i_x;
    assign pt[1] = i_y;
    assign pt[2] = i_z;

    // stage 1: twelve 32x32 products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < 4; c++) begin
                    r_prod[k][c] <= 64'(pt[k]) * 64'(mat_entry(i_mat, k, c));
                end
            end
        end
    end

    // stage 2: floor each product to the working fraction, add in pairs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_pa[c] <= SW'(r_prod[0][c] >>> FRAC_BITS) + SW'(r_prod[1][c] >>> FRAC_BITS);
                r_pb[c] <= SW'(r_prod[2][c] >>> FRAC_BITS) + SW'(mat_entry(i_mat, 3, c));
            end
        end
    end

    // stage 3: column sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_v[c] <= r_pa[c] + r_pb[c];
            end
        end
    end

    assign o_v = r_v;

endmodule

// File: rtl/vtp_div.sv
module vtp_div #(
    parameter int FRAC_BITS = 16,
    parameter int SW        = 50
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [SW-1:0]  i_v [3],
    input  logic signed [SW-1:0]  i_w,
    output vtp_pkg::t_word        o_res [3],
    output logic                  o_wz,
    output logic                  o_sat
);
    import vtp_pkg::*;

    localparam int NS = DIV_STEPS + 1;

    logic [63:0]           r_rem  [NS][3];
    logic [DIV_STEPS-1:0]  r_low  [NS][3];
    logic [DIV_STEPS-1:0]  r_quo  [NS][3];
    logic                  r_neg  [NS][3];
    logic                  r_big  [NS][3];
    t_word                 r_cl   [NS][3];
    logic                  r_csat [NS][3];
    logic [63:0]           r_uw   [NS];
    logic                  r_wz   [NS];

    // setup stage: magnitudes, dividend, early overflow check, clamp for zero w
    logic [SW-1:0] mag_w;
    assign mag_w = i_w[SW-1] ? SW'(-i_w) : SW'(i_w);

    always_ff @(posedge i_clk) begin
        logic [SW-1:0]        mag;
        logic [63:0]          dvd;
        logic [63:0]          rem0;
        logic signed [SW-1:0] hi;
        logic                 csat;
        if (i_en) begin
            r_uw[0] <= 64'(mag_w);
            r_wz[0] <= (i_w == '0);
            for (int l = 0; l < 3; l++) begin
                mag  = i_v[l][SW-1] ? SW'(-i_v[l]) : SW'(i_v[l]);
                dvd  = 64'(mag) << FRAC_BITS;
                rem0 = {33'b0, dvd[63:DIV_STEPS]};
                hi   = i_v[l] >>> (WORD_W - 1);
                csat = (hi != '0) && (hi != '1);
                r_rem[0][l]  <= rem0;
                r_low[0][l]  <= dvd[DIV_STEPS-1:0];
                r_quo[0][l]  <= '0;
                r_neg[0][l]  <= i_v[l][SW-1] ^ i_w[SW-1];
                r_big[0][l]  <= rem0 >= 64'(mag_w);
                r_csat[0][l] <= csat;
                r_cl[0][l]   <= csat ? (i_v[l][SW-1] ? WORD_MIN : WORD_MAX)
                                     : t_word'(i_v[l][WORD_W-1:0]);
            end
        end
    end

    // one restoring step per stage
    for (genvar s = 1; s < NS; s++) begin : g_step
        always_ff @(posedge i_clk) begin
            logic [63:0] t;
            logic        ge;
            if (i_en) begin
                r_uw[s] <= r_uw[s-1];
                r_wz[s] <= r_wz[s-1];
                for (int l = 0; l < 3; l++) begin
                    t  = {r_rem[s-1][l][62:0], r_low[s-1][l][DIV_STEPS-1]};
                    ge = t >= r_uw[s-1];
                    r_rem[s][l]  <= ge ? t - r_uw[s-1] : t;
                    r_low[s][l]  <= r_low[s-1][l] << 1;
                    r_quo[s][l]  <= {r_quo[s-1][l][DIV_STEPS-2:0], ge};
                    r_neg[s][l]  <= r_neg[s-1][l];
                    r_big[s][l]  <= r_big[s-1][l];
                    r_cl[s][l]   <= r_cl[s-1][l];
                    r_csat[s][l] <= r_csat[s-1][l];
                end
            end
        end
    end

    // sign, saturate, pick the undivided path for zero w
    always_comb begin
        logic [DIV_STEPS-1:0] q;
        logic                 ls;
        o_sat = 1'b0;
        for (int l = 0; l < 3; l++) begin
            q = r_quo[NS-1][l];
            if (r_wz[NS-1]) begin
                ls       = r_csat[NS-1][l];
                o_res[l] = r_cl[NS-1][l];
            end else if (!r_neg[NS-1][l]) begin
                ls       = r_big[NS-1][l] || (q > DIV_STEPS'(32'h7fff_ffff));
                o_res[l] = ls ? WORD_MAX : t_word'(q[WORD_W-1:0]);
            end else begin
                ls       = r_big[NS-1][l] || (q > DIV_STEPS'(32'h8000_0000));
                o_res[l] = ls ? WORD_MIN : t_word'(-q[WORD_W-1:0]);
            end
            o_sat = o_sat | ls;
        end
    end

    assign o_wz = r_wz[NS-1];

endmodule

// File: rtl/vertex_transform_perspective_divide.sv
// An accepted input word passes 3 multiply/sum stages, divider setup, 33 divider steps
// and an output register before its result word appears.
// Throughput: one word per cycle; a stalled output freezes the whole pipeline.
// Reset (synchronous, active low) empties the pipeline and loads the identity matrix.
module vertex_transform_perspective_divide #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vtp_in_if.sink            i_pt,
    vtp_out_if.source         o_res,
    input  logic              i_cfg_we,
    input  vtp_pkg::t_cfg_idx i_cfg_idx,
    input  logic [63:0]       i_cfg_data
);
    import vtp_pkg::*;

    localparam int SW  = 66 - FRAC_BITS;
    localparam int PIPE = 3 + 1 + DIV_STEPS;
    localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'd1 << FRAC_BITS);
    localparam logic [REG_W-1:0] ONE_HI = REG_W'(64'd1 << (FRAC_BITS + 32));

    t_mat                 r_mat;
    logic [PIPE-1:0]      r_vld;
    logic                 r_ov;
    t_word                r_ox, r_oy, r_oz;
    logic                 r_owz, r_osat;
    logic                 en;
    logic signed [SW-1:0] v [4];
    logic signed [SW-1:0] vd [3];
    t_word                res [3];
    logic                 wz, sat;

    // advance everything unless a result word is held
    assign en = !r_ov || o_res.ready;
    assign i_pt.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= '0;
            r_mat[REG_ROW0_C01] <= ONE_LO;
            r_mat[REG_ROW1_C01] <= ONE_HI;
            r_mat[REG_ROW2_C23] <= ONE_LO;
            r_mat[REG_ROW3_C23] <= ONE_HI;
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE-2:0], i_pt.valid};
            r_ov  <= r_vld[PIPE-1];
        end
    end

    vtp_mul #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_mul (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (i_pt.in_x),
        .i_y   (i_pt.in_y),
        .i_z   (i_pt.in_z),
        .i_mat (r_mat),
        .o_v   (v)
    );

    assign vd[0] = v[0];
    assign vd[1] = v[1];
    assign vd[2] = v[2];

    vtp_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_v   (vd),
        .i_w   (v[3]),
        .o_res (res),
        .o_wz  (wz),
        .o_sat (sat)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox   <= res[0];
            r_oy   <= res[1];
            r_oz   <= res[2];
            r_owz  <= wz;
            r_osat <= sat;
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.out_x      = r_ox;
    assign o_res.out_y      = r_oy;
    assign o_res.out_z      = r_oz;
    assign o_res.w_was_zero = r_owz;
    assign o_res.saturated  = r_osat;

endmodule

// File: rtl/vtp_chk.sv
module vtp_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input vtp_pkg::t_word    i_out_x,
    input vtp_pkg::t_word    i_out_y,
    input vtp_pkg::t_word    i_out_z,
    input logic              i_out_wz,
    input logic              i_out_sat
);
    import vtp_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not track output stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x)
            && $stable(i_out_y) && $stable(i_out_z) && $stable(i_out_wz)
            && $stable(i_out_sat))
        else $error("stalled result word changed");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_sat |->
            i_out_x == WORD_MAX || i_out_x == WORD_MIN ||
            i_out_y == WORD_MAX || i_out_y == WORD_MIN ||
            i_out_z == WORD_MAX || i_out_z == WORD_MIN)
        else $error("saturated flag without a clamped component");

endmodule

bind vertex_transform_perspective_divide vtp_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_x     (o_res.out_x),
    .i_out_y     (o_res.out_y),
    .i_out_z     (o_res.out_z),
    .i_out_wz    (o_res.w_was_zero),
    .i_out_sat   (o_res.saturated)
);

// File: test/vtp_result_checker.sv
module vtp_result_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vtp_in_if.sink            i_pt,
    vtp_out_if.sink           i_res,
    input  logic              i_cfg_we,
    input  vtp_pkg::t_cfg_idx i_cfg_idx,
    input  logic [63:0]       i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output logic              o_accept
);
    import vtp_pkg::*;

    localparam int FRAC = 16;

    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
        logic  wz;
        logic  sat;
    } t_vertex_out;

    logic [REG_W-1:0] matrix [MAT_REGS];
    t_vertex_out      expected_q [$];
    int               errors;
    int               pend;

    function automatic logic signed [95:0] coef(input int row, input int col);
        logic [REG_W-1:0] r;
        r = matrix[(row << 1) | ((col >> 1) & 1)];
        return (col & 1) ? 96'(signed'(r[63:32])) : 96'(signed'(r[31:0]));
    endfunction

    // clamp into 32 bits, raising the saturation flag when clipped
    function automatic t_word clip(input logic signed [95:0] v, inout logic sat);
        if (v > 96'sd2147483647) begin
            sat = 1'b1;
            return WORD_MAX;
        end
        if (v < -96'sd2147483648) begin
            sat = 1'b1;
            return WORD_MIN;
        end
        return t_word'(v);
    endfunction

    function automatic t_vertex_out transform_point(input t_word px, input t_word py,
                                                    input t_word pz);
        logic signed [95:0] pt [3];
        logic signed [95:0] col [4];
        logic signed [95:0] q;
        logic [95:0]        un, uw;
        logic               sat;
        t_word              res [3];
        t_vertex_out        r;
        pt[0] = 96'(px);
        pt[1] = 96'(py);
        pt[2] = 96'(pz);
        for (int c = 0; c < 4; c++) begin
            col[c] = coef(3, c);
            // arithmetic shift floors the exact product
            for (int k = 0; k < 3; k++)
                col[c] += (pt[k] * coef(k, c)) >>> FRAC;
        end
        sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            if (col[3] == 0) begin
                res[c] = clip(col[c], sat);
            end else begin
                un = col[c] < 0 ? -col[c] : col[c];
                uw = col[3] < 0 ? -col[3] : col[3];
                q  = signed'((un << FRAC) / uw);
                if ((col[c] < 0) != (col[3] < 0)) q = -q;
                res[c] = clip(q, sat);
            end
        end
        r.x   = res[0];
        r.y   = res[1];
        r.z   = res[2];
        r.wz  = (col[3] == 0);
        r.sat = sat;
        return r;
    endfunction

    assign o_errors  = errors;
    assign o_pending = pend;
    assign o_accept  = (i_pt.valid && i_pt.ready) || (i_res.valid && i_res.ready);

    always @(posedge i_clk) begin
        t_vertex_out e;
        if (!i_rst_n) begin
            for (int i = 0; i < MAT_REGS; i++) matrix[i] = '0;
            matrix[REG_ROW0_C01] = 64'h1_0000;
            matrix[REG_ROW1_C01] = 64'h1_0000 << 32;
            matrix[REG_ROW2_C23] = 64'h1_0000;
            matrix[REG_ROW3_C23] = 64'h1_0000 << 32;
            expected_q.delete();
            errors = 0;
        end else begin
            if (i_cfg_we) matrix[i_cfg_idx] = i_cfg_data;
            if (i_pt.valid && i_pt.ready)
                expected_q.push_back(transform_point(i_pt.in_x, i_pt.in_y, i_pt.in_z));
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result word");
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (i_res.out_x !== e.x) begin
                        $error("out_x exp %0d got %0d", e.x, i_res.out_x);
                        errors++;
                    end
                    if (i_res.out_y !== e.y) begin
                        $error("out_y exp %0d got %0d", e.y, i_res.out_y);
                        errors++;
                    end
                    if (i_res.out_z !== e.z) begin
                        $error("out_z exp %0d got %0d", e.z, i_res.out_z);
                        errors++;
                    end
                    if (i_res.w_was_zero !== e.wz) begin
                        $error("w_was_zero exp %0b got %0b", e.wz, i_res.w_was_zero);
                        errors++;
                    end
                    if (i_res.saturated !== e.sat) begin
                        $error("saturated exp %0b got %0b", e.sat, i_res.saturated);
                        errors++;
                    end
                end
            end
        end
        pend = expected_q.size();
    end
endmodule

// File: test/vertex_transform_perspective_divide_tb.sv
module vertex_transform_perspective_divide_tb;
    import vtp_pkg::*;

    localparam int  WATCHDOG = 5000;
    localparam int  LATENCY  = 38;
    localparam int  RAND_N   = 1625;
    localparam logic [63:0] ONE = 64'h1_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [63:0] i_cfg_data;
    int          errors;
    int          pending;
    logic        accept;
    int          idle_cycles;
    logic        timed_out;
    logic        quiet;

    vtp_in_if  pt_if ();
    vtp_out_if res_if ();

    vertex_transform_perspective_divide u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pt      (pt_if.sink),
        .o_res     (res_if.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    vtp_result_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pt      (pt_if.sink),
        .i_res     (res_if.sink),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_errors  (errors),
        .o_pending (pending),
        .o_accept  (accept)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || accept) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end
    assign timed_out = (idle_cycles >= WATCHDOG);

    // receiver side: random stall bursts unless quiet
    initial begin
        int n;
        res_if.ready = 1'b0;
        @(posedge i_clk);
        while (1) begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                res_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_point(input t_word x, input t_word y, input t_word z);
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            pt_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.in_x  <= x;
        pt_if.in_y  <= y;
        pt_if.in_z  <= z;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
    endtask

    // let the last accepted word reach the checker before counting what is left
    task automatic drain();
        pt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && !timed_out) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_word rand_coord(input int mode);
        case (mode)
            0: return t_word'($urandom);
            1: return t_word'($urandom_range(0, 32'h000f_ffff)) - t_word'(32'h0008_0000);
            2: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
            default: return t_word'($urandom_range(0, 8)) <<< 16;
        endcase
    endfunction

    // entries with a sign bit near or far; mixes small and full scale
    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'h0;
            2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            default: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
        endcase
    endfunction

    task automatic load_matrix(input int style);
        logic [31:0] lo, hi;
        for (int i = 0; i < MAT_REGS; i++) begin
            case (style)
                0: begin lo = 32'h7fff_ffff; hi = 32'h8000_0000; end
                1: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
                2: begin lo = 32'h0;         hi = 32'h0;         end
                default: begin lo = rand_entry(); hi = rand_entry(); end
            endcase
            cfg_write(t_cfg_idx'(i), {hi, lo});
        end
    endtask

    task automatic identity_w(input logic [31:0] w_bias);
        cfg_write(REG_ROW0_C01, ONE);
        cfg_write(REG_ROW0_C23, '0);
        cfg_write(REG_ROW1_C01, ONE << 32);
        cfg_write(REG_ROW1_C23, '0);
        cfg_write(REG_ROW2_C01, '0);
        cfg_write(REG_ROW2_C23, ONE);
        cfg_write(REG_ROW3_C01, '0);
        cfg_write(REG_ROW3_C23, {w_bias, 32'h0});
    endtask

    initial begin
        t_word dv [6];
        int    phase_len;
        quiet       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        pt_if.valid = 1'b0;
        pt_if.in_x  = '0;
        pt_if.in_y  = '0;
        pt_if.in_z  = '0;
        fork
            begin
                repeat (7) @(posedge i_clk);
                i_rst_n <= 1'b1;
                @(posedge i_clk);
                dv = '{32'sh0, 32'sh1_0000, WORD_MAX, WORD_MIN, -32'sh1, 32'sh1};
                // reset identity matrix, extreme coordinates
                foreach (dv[i]) send_point(dv[i], dv[(i + 2) % 6], dv[(i + 4) % 6]);
                drain();
                // zero w: pass-through of small and extreme coordinates
                identity_w(32'h0);
                send_point(32'sh1234, -32'sh5678, 32'sh0);
                send_point(WORD_MAX, WORD_MIN, WORD_MAX);
                drain();
                load_matrix(0);
                send_point(WORD_MAX, WORD_MAX, WORD_MAX);
                send_point(WORD_MIN, WORD_MAX, WORD_MIN);
                drain();
                load_matrix(1);
                send_point(WORD_MIN, WORD_MIN, WORD_MIN);
                send_point(32'sh1_0000, -32'sh1_0000, 32'sh0);
                drain();
                load_matrix(2);
                send_point(WORD_MAX, WORD_MIN, 32'sh7);
                drain();
                // tiny w forces divide overflow; negative w flips signs
                identity_w(32'h0000_0001);
                send_point(32'sh10_0000, -32'sh10_0000, 32'sh1);
                send_point(32'sh0, 32'sh0, 32'sh0);
                drain();
                identity_w(32'hfffe_0000);
                send_point(32'sh3_0001, -32'sh3_0001, WORD_MIN);
                drain();
                for (int ph = 0; ph < 16; ph++) begin
                    if (ph == 15) quiet = 1'b1;
                    case (ph % 4)
                        0: identity_w($urandom_range(0, 3) == 0 ? 32'h0 : rand_entry());
                        default: load_matrix(3);
                    endcase
                    phase_len = RAND_N / 16;
                    for (int n = 0; n < phase_len; n++)
                        send_point(rand_coord($urandom_range(0, 3)),
                                   rand_coord($urandom_range(0, 3)),
                                   rand_coord($urandom_range(0, 3)));
                    drain();
                end
            end
            begin
                wait (timed_out);
            end
        join_any
        if (timed_out) begin
            $display("Test completed with failures");
        end else if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
